@@ sv/ltm_pkg.sv @@
// ----------------------------------------------------------------------------
// ltm_pkg: shared types and codes of the lock table manager
// Result kinds, request actions and the request token that walks the cell row.
// ----------------------------------------------------------------------------
package ltm_pkg;

  localparam int LOCK_W   = 64;
  localparam int CLIENT_W = 4;
  localparam int KIND_W   = 3;
  localparam int GRANT_W  = 32;

  // request actions
  localparam logic ACT_ACQUIRE = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_GRANTED  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_QUEUED   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_IGNORED  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FULL     = 3'd4;

  // request token handed from cell to cell
  typedef struct packed {
    logic                action;
    logic [CLIENT_W-1:0] client;
    logic [LOCK_W-1:0]   lock;
    logic                done;       // some cell has settled the request
    logic [KIND_W-1:0]   kind;       // first result kind once done
    logic                handover;   // a second result goes to the new holder
    logic [CLIENT_W-1:0] new_holder;
    logic                grant;      // the request made one grant
  } ltm_tok_t;

endpackage

@@ sv/ltm_cell.sv @@
// ----------------------------------------------------------------------------
// ltm_cell: one slot of the lock table
// Holds one lock entry and settles a passing request that names its key, or
// takes the key in when it is the first free slot of the row.
// ----------------------------------------------------------------------------
module ltm_cell #(
  parameter int CLIENT_COUNT = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tok_v_i,
  input  ltm_pkg::ltm_tok_t tok_i,
  output logic             tok_v_o,
  output ltm_pkg::ltm_tok_t tok_o
);
  import ltm_pkg::*;

  logic                    used_r, used_nxt;
  logic [LOCK_W-1:0]       key_r, key_nxt;
  logic                    held_r, held_nxt;
  logic [CLIENT_W-1:0]     holder_r, holder_nxt;
  logic [CLIENT_COUNT-1:0] wait_r, wait_nxt;
  logic                    tok_v_r;
  ltm_tok_t                tok_r, tok_nxt;

  logic                    key_hit;
  logic                    active;
  logic [CLIENT_COUNT-1:0] wait_bit;
  logic [CLIENT_COUNT-1:0] lowest;
  logic [CLIENT_W-1:0]     waiter_idx;

  assign key_hit  = used_r && (key_r == tok_i.lock);
  assign active   = tok_v_i && !tok_i.done;
  assign wait_bit = CLIENT_COUNT'(1) << tok_i.client;

  // lowest waiter as a one-hot mask, then its index
  assign lowest = wait_r & (~wait_r + CLIENT_COUNT'(1));

  always_comb begin
    waiter_idx = '0;
    for (int i = 0; i < CLIENT_COUNT; i++) begin
      if (lowest[i]) waiter_idx = waiter_idx | CLIENT_W'(i);
    end
  end

  // slot update and token verdict
  always_comb begin
    used_nxt   = used_r;
    key_nxt    = key_r;
    held_nxt   = held_r;
    holder_nxt = holder_r;
    wait_nxt   = wait_r;
    tok_nxt    = tok_i;
    if (active) begin
      if (tok_i.action == ACT_ACQUIRE) begin
        if (key_hit) begin
          tok_nxt.done = 1'b1;
          if (!held_r) begin
            held_nxt      = 1'b1;
            holder_nxt    = tok_i.client;
            tok_nxt.kind  = KIND_GRANTED;
            tok_nxt.grant = 1'b1;
          end else begin
            wait_nxt     = wait_r | wait_bit;
            tok_nxt.kind = KIND_QUEUED;
          end
        end else if (!used_r) begin
          // slots fill from the front, so this is the lowest free one
          used_nxt      = 1'b1;
          key_nxt       = tok_i.lock;
          held_nxt      = 1'b1;
          holder_nxt    = tok_i.client;
          wait_nxt      = '0;
          tok_nxt.done  = 1'b1;
          tok_nxt.kind  = KIND_GRANTED;
          tok_nxt.grant = 1'b1;
        end
      end else begin
        if (key_hit) begin
          tok_nxt.done = 1'b1;
          if (!held_r || (holder_r != tok_i.client)) begin
            tok_nxt.kind = KIND_IGNORED;
          end else if (wait_r == '0) begin
            held_nxt     = 1'b0;
            tok_nxt.kind = KIND_RELEASED;
          end else begin
            wait_nxt           = wait_r & ~lowest;
            holder_nxt         = waiter_idx;
            tok_nxt.kind       = KIND_RELEASED;
            tok_nxt.handover   = 1'b1;
            tok_nxt.new_holder = waiter_idx;
            tok_nxt.grant      = 1'b1;
          end
        end else if (!used_r) begin
          // no used slot lies past the first free one
          tok_nxt.done = 1'b1;
          tok_nxt.kind = KIND_IGNORED;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= 1'b0;
      held_r  <= 1'b0;
      wait_r  <= '0;
      tok_v_r <= 1'b0;
    end else begin
      used_r  <= used_nxt;
      held_r  <= held_nxt;
      wait_r  <= wait_nxt;
      tok_v_r <= tok_v_i;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    holder_r <= holder_nxt;
    tok_r    <= tok_nxt;
  end

  assign tok_v_o = tok_v_r;
  assign tok_o   = tok_r;

endmodule

@@ sv/lock_table_manager_core.sv @@
// ----------------------------------------------------------------------------
// lock_table_manager_core: mutex table keyed by a 64-bit lock id
// A row of slot cells settles acquire and release requests in order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries one request: action (0 acquire,
//   1 release), client and lock_id. Output channel out_valid/out_stall carries
//   the results: one per request, or two for a release that hands the lock to
//   the lowest waiter (released to the old holder with last=0, then granted
//   to the new holder with last=1). Every result carries the grant count.
//   A request is injected into a head register and walks the row of
//   LOCK_SLOTS cells, one cell per cycle; the result registers then take
//   its first result. One request is in the row at a time; the next one is
//   taken in the cycle the last result of the previous one leaves, so a new
//   request is not taken before the previous one is through. The walk along
//   the cell row sets the pace of requests.
//   Reset empties the table and clears the grant count at once. While the
//   receiver stalls, the pending result holds and no new request is taken.
// ----------------------------------------------------------------------------
module lock_table_manager_core #(
  parameter int LOCK_SLOTS   = 16,
  parameter int CLIENT_COUNT = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_action,
  input  logic [ltm_pkg::CLIENT_W-1:0]        in_client,
  input  logic [ltm_pkg::LOCK_W-1:0]          in_lock_id,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ltm_pkg::CLIENT_W-1:0]        out_target_client,
  output logic [ltm_pkg::LOCK_W-1:0]          out_result_lock,
  output logic [ltm_pkg::KIND_W-1:0]          out_kind,
  output logic [ltm_pkg::GRANT_W-1:0]         out_grants_so_far,
  output logic                                out_last
);
  import ltm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_OUT1 = 4'b0100,
    ST_OUT2 = 4'b1000
  } ltm_state_t;

  ltm_state_t          state_r, state_nxt;
  logic                head_v_r;
  ltm_tok_t            head_r, head_nxt;
  logic [GRANT_W-1:0]  grant_r, grant_nxt;
  logic [CLIENT_W-1:0] res_client_r, res_client_nxt;
  logic [LOCK_W-1:0]   res_lock_r, res_lock_nxt;
  logic [KIND_W-1:0]   res_kind_r, res_kind_nxt;
  logic                res_last_r, res_last_nxt;
  logic [CLIENT_W-1:0] res_holder_r, res_holder_nxt;

  logic                chain_v   [LOCK_SLOTS+1];
  ltm_tok_t            chain_tok [LOCK_SLOTS+1];
  logic                in_accept;
  logic                out_take;
  logic                tail_v;
  ltm_tok_t            tail_tok;

  // request acceptance
  assign out_take  = out_valid && !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) || (out_take && res_last_r));
  assign in_accept = in_valid && !in_stall;

  // head token; out-of-range clients are settled before the walk
  always_comb begin
    head_nxt            = '0;
    head_nxt.action     = in_action;
    head_nxt.client     = in_client;
    head_nxt.lock       = in_lock_id;
    head_nxt.kind       = KIND_IGNORED;
    head_nxt.done       = (32'(in_client) >= 32'(CLIENT_COUNT));
  end

  assign chain_v[0]   = head_v_r;
  assign chain_tok[0] = head_r;

  // row of slot cells
  for (genvar g = 0; g < LOCK_SLOTS; g++) begin : g_cell
    ltm_cell #(
      .CLIENT_COUNT(CLIENT_COUNT)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_v_i (chain_v[g]),
      .tok_i   (chain_tok[g]),
      .tok_v_o (chain_v[g+1]),
      .tok_o   (chain_tok[g+1])
    );
  end

  assign tail_v   = chain_v[LOCK_SLOTS];
  assign tail_tok = chain_tok[LOCK_SLOTS];

  // sequencer and result registers
  always_comb begin
    state_nxt      = state_r;
    grant_nxt      = grant_r;
    res_client_nxt = res_client_r;
    res_lock_nxt   = res_lock_r;
    res_kind_nxt   = res_kind_r;
    res_last_nxt   = res_last_r;
    res_holder_nxt = res_holder_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (tail_v) begin
          state_nxt      = ST_OUT1;
          grant_nxt      = grant_r + GRANT_W'(tail_tok.grant);
          res_client_nxt = tail_tok.client;
          res_lock_nxt   = tail_tok.lock;
          res_last_nxt   = !tail_tok.handover;
          res_holder_nxt = tail_tok.new_holder;
          if (tail_tok.done) begin
            res_kind_nxt = tail_tok.kind;
          end else if (tail_tok.action == ACT_ACQUIRE) begin
            res_kind_nxt = KIND_FULL;
          end else begin
            res_kind_nxt = KIND_IGNORED;
          end
        end
      end
      ST_OUT1: begin
        if (out_take) begin
          if (!res_last_r) begin
            state_nxt      = ST_OUT2;
            res_client_nxt = res_holder_r;
            res_kind_nxt   = KIND_GRANTED;
            res_last_nxt   = 1'b1;
          end else if (in_accept) begin
            state_nxt = ST_RUN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_OUT2: begin
        if (out_take) begin
          state_nxt = in_accept ? ST_RUN : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      head_v_r <= 1'b0;
      grant_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      head_v_r <= in_accept;
      grant_r  <= grant_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_accept) head_r <= head_nxt;
    res_client_r <= res_client_nxt;
    res_lock_r   <= res_lock_nxt;
    res_kind_r   <= res_kind_nxt;
    res_last_r   <= res_last_nxt;
    res_holder_r <= res_holder_nxt;
  end

  assign out_valid         = (state_r == ST_OUT1) || (state_r == ST_OUT2);
  assign out_target_client = res_client_r;
  assign out_result_lock   = res_lock_r;
  assign out_kind          = res_kind_r;
  assign out_grants_so_far = grant_r;
  assign out_last          = res_last_r;

`ifndef ASSERT_OFF
  // a request leaves the row only while the sequencer waits for it
  a_tail_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    tail_v |-> (state_r == ST_RUN))
    else $error("token left the cell row outside the run state");

  // only a handover release has a result after it
  a_first_is_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_kind == KIND_RELEASED))
    else $error("non-final result is not a release");

  // the handover result grants the lock with an unchanged count
  a_handover_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last && !out_stall) |=>
      (out_valid && out_last && (out_kind == KIND_GRANTED) && $stable(out_grants_so_far)))
    else $error("handover did not produce a grant");
`endif

endmodule

@@ sim/lock_table_manager_core_tb.sv @@
// ----------------------------------------------------------------------------
// lock_table_manager_core_tb: self-checking bench for the lock table manager
// Drives acquire and release requests through the valid/stall channels and
// predicts every reply from a private copy of the lock table. The bench starts
// with directed cases: handover, queuing, ignored releases and table full.
// Random phases then mix idle and stall pressure.
// ----------------------------------------------------------------------------
module lock_table_manager_core_tb;

  import ltm_pkg::*;

  localparam int LOCK_SLOTS   = 16;
  localparam int CLIENT_COUNT = 16;
  localparam int PHASE_ITEMS  = 450;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 2 * LOCK_SLOTS + 8;
  localparam int CYCLE_LIMIT  = 600000;

  // one reply as seen on the result channel
  typedef struct {
    logic [CLIENT_W-1:0] target;
    logic [LOCK_W-1:0]   lock;
    logic [KIND_W-1:0]   kind;
    logic [GRANT_W-1:0]  grants;
    logic                last;
  } lock_reply_t;

  // lock table copy, reply prediction and reply checking
  class lock_reply_board;
    bit                  used[LOCK_SLOTS];
    logic [LOCK_W-1:0]   key[LOCK_SLOTS];
    bit                  held[LOCK_SLOTS];
    logic [CLIENT_W-1:0] holder[LOCK_SLOTS];
    logic [15:0]         waiting[LOCK_SLOTS];
    logic [GRANT_W-1:0]  grant_total;
    lock_reply_t         awaited_replies[$];
    int                  mismatches;

    function new();
      for (int i = 0; i < LOCK_SLOTS; i++) begin
        used[i]    = 1'b0;
        held[i]    = 1'b0;
        waiting[i] = '0;
      end
      grant_total = '0;
      mismatches  = 0;
    endfunction

    function int pending();
      return awaited_replies.size();
    endfunction

    function int find_key(logic [LOCK_W-1:0] lock);
      for (int i = 0; i < LOCK_SLOTS; i++)
        if (used[i] && key[i] == lock) return i;
      return -1;
    endfunction

    function int find_free();
      for (int i = 0; i < LOCK_SLOTS; i++)
        if (!used[i]) return i;
      return -1;
    endfunction

    // accepted request: update the table and queue the replies it causes
    function void note_request(logic action, logic [CLIENT_W-1:0] client,
                               logic [LOCK_W-1:0] lock);
      lock_reply_t r[2];
      int          n;
      int          s;
      int          w;
      n = 0;
      if (client >= CLIENT_COUNT) begin
        r[n++] = '{client, lock, KIND_IGNORED, '0, 1'b1};
      end else if (action == ACT_ACQUIRE) begin
        s = find_key(lock);
        if (s < 0) begin
          s = find_free();
          if (s < 0) begin
            r[n++] = '{client, lock, KIND_FULL, '0, 1'b1};
          end else begin
            used[s]    = 1'b1;
            key[s]     = lock;
            held[s]    = 1'b1;
            holder[s]  = client;
            waiting[s] = '0;
            grant_total++;
            r[n++] = '{client, lock, KIND_GRANTED, '0, 1'b1};
          end
        end else if (!held[s]) begin
          held[s]   = 1'b1;
          holder[s] = client;
          grant_total++;
          r[n++] = '{client, lock, KIND_GRANTED, '0, 1'b1};
        end else begin
          waiting[s][client] = 1'b1;
          r[n++] = '{client, lock, KIND_QUEUED, '0, 1'b1};
        end
      end else begin
        s = find_key(lock);
        if (s < 0 || !held[s] || holder[s] != client) begin
          r[n++] = '{client, lock, KIND_IGNORED, '0, 1'b1};
        end else if (waiting[s] == '0) begin
          held[s] = 1'b0;
          r[n++] = '{client, lock, KIND_RELEASED, '0, 1'b1};
        end else begin
          // hand over to the lowest-numbered waiter
          w = 0;
          while (!waiting[s][w]) w++;
          waiting[s][w] = 1'b0;
          holder[s]     = w[CLIENT_W-1:0];
          grant_total++;
          r[n++] = '{client, lock, KIND_RELEASED, '0, 1'b0};
          r[n++] = '{w[CLIENT_W-1:0], lock, KIND_GRANTED, '0, 1'b1};
        end
      end
      // every reply of one request carries the final grant count
      for (int k = 0; k < n; k++) begin
        r[k].grants = grant_total;
        awaited_replies.push_back(r[k]);
      end
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("mismatch: %s", what);
    endtask

    // accepted reply: compare field by field with the oldest prediction
    task check_reply(lock_reply_t got);
      lock_reply_t exp;
      if (awaited_replies.size() == 0) begin
        report_mismatch($sformatf("reply with none awaited, client %0d lock %h kind %0d",
                                  got.target, got.lock, got.kind));
      end else begin
        exp = awaited_replies.pop_front();
        if (got.target !== exp.target)
          report_mismatch($sformatf("target_client %0d, want %0d", got.target, exp.target));
        if (got.lock !== exp.lock)
          report_mismatch($sformatf("result_lock %h, want %h", got.lock, exp.lock));
        if (got.kind !== exp.kind)
          report_mismatch($sformatf("kind %0d, want %0d (lock %h)",
                                    got.kind, exp.kind, exp.lock));
        if (got.grants !== exp.grants)
          report_mismatch($sformatf("grants_so_far %0d, want %0d", got.grants, exp.grants));
        if (got.last !== exp.last)
          report_mismatch($sformatf("last %b, want %b", got.last, exp.last));
      end
    endtask
  endclass

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  logic                in_action  = ACT_ACQUIRE;
  logic [CLIENT_W-1:0] in_client  = '0;
  logic [LOCK_W-1:0]   in_lock_id = '0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  logic [CLIENT_W-1:0] out_target_client;
  logic [LOCK_W-1:0]   out_result_lock;
  logic [KIND_W-1:0]   out_kind;
  logic [GRANT_W-1:0]  out_grants_so_far;
  logic                out_last;

  lock_reply_board board;
  int              sender_idle_pct    = 0;
  int              receiver_stall_pct = 0;
  int              hold_req           = 0;
  int              hold_left          = 0;
  int              cycle_count        = 0;

  lock_table_manager_core #(
    .LOCK_SLOTS  (LOCK_SLOTS),
    .CLIENT_COUNT(CLIENT_COUNT)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_client        (in_client),
    .in_lock_id       (in_lock_id),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_target_client(out_target_client),
    .out_result_lock  (out_result_lock),
    .out_kind         (out_kind),
    .out_grants_so_far(out_grants_so_far),
    .out_last         (out_last)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // reply monitor
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall)
      board.check_reply('{out_target_client, out_result_lock, out_kind,
                          out_grants_so_far, out_last});
  end

  function automatic int draw_gap(int pct);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < pct) gap++;
    return gap;
  endfunction

  function automatic logic [LOCK_W-1:0] fresh_lock();
    return {$urandom, $urandom};
  endfunction

  // offer one request and wait until it is taken
  task automatic send_request(input logic action, input logic [CLIENT_W-1:0] client,
                              input logic [LOCK_W-1:0] lock);
    int gap;
    gap = draw_gap(sender_idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= action;
    in_client  <= client;
    in_lock_id <= lock;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    board.note_request(action, client, lock);
  endtask

  // sender pauses until every predicted reply has come
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // mostly known locks, holder releases, some fresh ids that hit a full table
  task automatic send_random_request();
    logic                action;
    logic [CLIENT_W-1:0] client;
    logic [LOCK_W-1:0]   lock;
    int                  s;
    s      = $urandom_range(LOCK_SLOTS - 1);
    action = 1'($urandom_range(1));
    client = CLIENT_W'($urandom_range(CLIENT_COUNT - 1));
    if ($urandom_range(99) < 8 || !board.used[s]) lock = fresh_lock();
    else lock = board.key[s];
    if (action == ACT_RELEASE && board.used[s] && lock == board.key[s] && board.held[s] &&
        $urandom_range(99) < 70)
      client = board.holder[s];
    send_request(action, client, lock);
  endtask

  // directed cases on an empty table
  task automatic run_directed();
    logic [LOCK_W-1:0] k0;
    logic [LOCK_W-1:0] k1;
    k0 = '0;
    k1 = '1;
    send_request(ACT_ACQUIRE, 4'd0, k0);   // new lock granted
    send_request(ACT_ACQUIRE, 4'd5, k0);   // held: queued
    send_request(ACT_ACQUIRE, 4'd3, k0);
    send_request(ACT_ACQUIRE, 4'd0, k0);   // holder queues itself
    send_request(ACT_ACQUIRE, 4'd5, k0);   // already queued
    send_request(ACT_RELEASE, 4'd7, k0);   // non-holder: ignored
    send_request(ACT_RELEASE, 4'd9, k1);   // unknown lock: ignored
    send_request(ACT_RELEASE, 4'd0, k0);   // handed back to the holder
    send_request(ACT_RELEASE, 4'd0, k0);   // handover to 3
    send_request(ACT_RELEASE, 4'd3, k0);   // handover to 5
    send_request(ACT_RELEASE, 4'd5, k0);   // no waiters: released
    send_request(ACT_RELEASE, 4'd5, k0);   // free lock: ignored
    send_request(ACT_ACQUIRE, 4'd15, k0);  // free lock granted
    send_request(ACT_ACQUIRE, 4'd15, k1);
    // fill the rest of the table, then overflow it
    for (int i = 2; i < LOCK_SLOTS; i++)
      send_request(ACT_ACQUIRE, CLIENT_W'($urandom_range(CLIENT_COUNT - 1)), fresh_lock());
    send_request(ACT_ACQUIRE, 4'd10, fresh_lock());
  endtask

  initial begin
    board = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    wait_drained();

    // random phases: none (plus one long receiver hold), sender idle, receiver stall, both
    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct    = (phase == 1) ? 68 : (phase == 3) ? 37 : 0;
      receiver_stall_pct = (phase == 2) ? 68 : (phase == 3) ? 37 : 0;
      if (phase == 0) hold_req = LONG_HOLD;
      for (int i = 0; i < PHASE_ITEMS; i++) send_random_request();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ lock_table_manager_core.f @@
sv/ltm_pkg.sv
sv/ltm_cell.sv
sv/lock_table_manager_core.sv
sim/lock_table_manager_core_tb.sv
